// ===== rtl/voice_slot_allocator_core_defines.svh =====
// assertion macros used by the checker file
`ifndef VOICE_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define VOICE_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// concurrent assertion on clk_i, off while rst_ni is low
`define VSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// antecedent in one cycle, consequent in the next
`define VSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  `VSA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/vsa_pkg.sv =====
package vsa_pkg;

  // fixed field widths
  localparam int unsigned WAIT_W  = 32;
  localparam int unsigned DUR_W   = 32;
  localparam int unsigned VOICE_W = 4;
  localparam int unsigned USED_W  = 5;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_LOAD
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== rtl/vsa_if.sv =====
// event channel
interface vsa_evt_if;
  logic                        valid;
  logic                        ready;
  logic [vsa_pkg::WAIT_W-1:0]  wait_time_ms;
  logic                        continues_voice;
  logic [vsa_pkg::VOICE_W-1:0] previous_voice;
  logic                        used_later;
  logic                        sets_graph;
  logic [vsa_pkg::DUR_W-1:0]   graph_duration_ms;

  modport source (
    output valid, wait_time_ms, continues_voice, previous_voice, used_later,
           sets_graph, graph_duration_ms,
    input  ready
  );
  modport sink (
    input  valid, wait_time_ms, continues_voice, previous_voice, used_later,
           sets_graph, graph_duration_ms,
    output ready
  );
endinterface

// result channel
interface vsa_res_if;
  logic                        valid;
  logic                        ready;
  logic [vsa_pkg::VOICE_W-1:0] voice_index;
  logic                        no_free_voice;
  logic [vsa_pkg::USED_W-1:0]  voices_used;

  modport source (
    output valid, voice_index, no_free_voice, voices_used,
    input  ready
  );
  modport sink (
    input  valid, voice_index, no_free_voice, voices_used,
    output ready
  );
endinterface

// ===== rtl/voice_slot_allocator_core.sv =====
// voice slot allocator
// evt_i takes one event per item (valid/ready); res_o returns one result per
// event: the slot chosen, a flag when no slot could be given, and the number
// of slots allocated so far.
// each event first counts down every allocated slot by its wait time in a
// sweep over the slot store, one slot per cycle on its single read port,
// while the lowest expired slot without a later-use mark is located.
// the sweep is skipped while no slot is allocated, and the next event is
// accepted in the cycle after the result is loaded.
// the result sits in an output register: a stalled receiver holds it there,
// and a following event is taken and swept meanwhile, waiting only for the
// register to free up before it loads its own result.
// reset empties the store logically (slot count zero) and clears all
// control state; the store itself needs no clearing, as slots are only
// read once allocated.
module voice_slot_allocator_core #(
  parameter int unsigned MAX_VOICES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  vsa_evt_if.sink  evt_i,
  vsa_res_if.source res_o
);

  vsa_pkg::ctrl_cmd_t    cmd;
  vsa_pkg::ctrl_status_t status;
  logic                  evt_ready;

  // controller
  vsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_i.valid),
    .evt_ready_o (evt_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  assign evt_i.ready = evt_ready;

  // datapath
  vsa_datapath #(
    .MAX_VOICES (MAX_VOICES)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .wait_time_ms_i      (evt_i.wait_time_ms),
    .continues_voice_i   (evt_i.continues_voice),
    .previous_voice_i    (evt_i.previous_voice),
    .used_later_i        (evt_i.used_later),
    .sets_graph_i        (evt_i.sets_graph),
    .graph_duration_ms_i (evt_i.graph_duration_ms),
    .out_ready_i         (res_o.ready),
    .out_valid_o         (res_o.valid),
    .voice_index_o       (res_o.voice_index),
    .no_free_voice_o     (res_o.no_free_voice),
    .voices_used_o       (res_o.voices_used)
  );

endmodule

// ===== rtl/vsa_ctrl.sv =====
module vsa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  evt_valid_i,
  output logic                  evt_ready_o,
  input  vsa_pkg::ctrl_status_t status_i,
  output vsa_pkg::ctrl_cmd_t    cmd_o
);

  vsa_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vsa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vsa_pkg::ST_IDLE: begin
        if (evt_valid_i) begin
          state_d = status_i.count_zero ? vsa_pkg::ST_LOAD : vsa_pkg::ST_SCAN;
        end
      end
      vsa_pkg::ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = vsa_pkg::ST_FLUSH;
        end
      end
      vsa_pkg::ST_FLUSH: begin
        state_d = vsa_pkg::ST_LOAD;
      end
      vsa_pkg::ST_LOAD: begin
        if (status_i.out_free) begin
          state_d = vsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vsa_pkg::ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    evt_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      vsa_pkg::ST_IDLE: begin
        evt_ready_o = 1'b1;
        cmd_o.start = evt_valid_i;
      end
      vsa_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      vsa_pkg::ST_FLUSH: begin
        cmd_o = '0;
      end
      vsa_pkg::ST_LOAD: begin
        cmd_o.load = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/vsa_datapath.sv =====
module vsa_datapath #(
  parameter int unsigned MAX_VOICES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vsa_pkg::ctrl_cmd_t          cmd_i,
  output vsa_pkg::ctrl_status_t       status_o,
  input  logic [vsa_pkg::WAIT_W-1:0]  wait_time_ms_i,
  input  logic                        continues_voice_i,
  input  logic [vsa_pkg::VOICE_W-1:0] previous_voice_i,
  input  logic                        used_later_i,
  input  logic                        sets_graph_i,
  input  logic [vsa_pkg::DUR_W-1:0]   graph_duration_ms_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [vsa_pkg::VOICE_W-1:0] voice_index_o,
  output logic                        no_free_voice_o,
  output logic [vsa_pkg::USED_W-1:0]  voices_used_o
);

  localparam int unsigned IDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_VOICES + 1);
  localparam int unsigned ENT_W = vsa_pkg::DUR_W + 1;

  // latched item
  logic [vsa_pkg::WAIT_W-1:0]  wait_q;
  logic                        cont_q;
  logic [vsa_pkg::VOICE_W-1:0] prev_q;
  logic                        mark_q;
  logic                        graph_q;
  logic [vsa_pkg::DUR_W-1:0]   dur_q;

  // slot store: {later-use mark, remaining ms}
  logic [ENT_W-1:0] mem_q [MAX_VOICES];
  logic [ENT_W-1:0] rd_data_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;

  // sweep control
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_idx_q;
  logic             rd_pend_q;
  logic [IDX_W-1:0] rd_addr_q;
  logic             found_q;
  logic [IDX_W-1:0] found_idx_q;

  // result register
  logic                        out_valid_q;
  logic [vsa_pkg::VOICE_W-1:0] out_index_q;
  logic                        out_fail_q;
  logic [vsa_pkg::USED_W-1:0]  out_used_q;

  // countdown of the entry read back
  logic [vsa_pkg::DUR_W-1:0] rem;
  logic                      ent_mark;
  logic [vsa_pkg::DUR_W:0]   diff;
  logic [vsa_pkg::DUR_W-1:0] rem_next;
  logic                      free_hit;

  assign rem      = rd_data_q[vsa_pkg::DUR_W-1:0];
  assign ent_mark = rd_data_q[vsa_pkg::DUR_W];
  assign diff     = {1'b0, rem} - {1'b0, wait_q};
  assign rem_next = diff[vsa_pkg::DUR_W] ? '0 : diff[vsa_pkg::DUR_W-1:0];
  assign free_hit = rd_pend_q && !ent_mark && (rem_next == '0) && !found_q;

  // slot choice
  logic        prev_ok;
  logic        count_full;
  logic [31:0] prev_wide;
  logic        ld_we;
  logic        ld_fail;
  logic [IDX_W-1:0] ld_addr;
  logic [31:0] ld_slot_wide;
  logic [31:0] used_wide;

  assign prev_wide  = 32'(prev_q);
  assign prev_ok    = prev_wide < 32'(MAX_VOICES);
  assign count_full = count_q == CNT_W'(MAX_VOICES);
  assign used_wide  = 32'(count_d);

  always_comb begin
    ld_we        = 1'b0;
    ld_fail      = 1'b0;
    ld_addr      = found_idx_q;
    ld_slot_wide = '0;
    count_d      = count_q;
    if (cont_q) begin
      ld_slot_wide = prev_wide;
      ld_addr      = prev_wide[IDX_W-1:0];
      if (prev_ok) begin
        ld_we = 1'b1;
      end else begin
        ld_fail = 1'b1;
      end
    end else if (found_q) begin
      ld_we        = 1'b1;
      ld_addr      = found_idx_q;
      ld_slot_wide = 32'(found_idx_q);
    end else if (!count_full) begin
      ld_we        = 1'b1;
      ld_addr      = count_q[IDX_W-1:0];
      ld_slot_wide = 32'(count_q);
      count_d      = count_q + CNT_W'(1);
    end else begin
      ld_fail = 1'b1;
    end
  end

  // write port: sweep write-back or final slot load
  assign mem_we    = rd_pend_q || (cmd_i.load && ld_we);
  assign mem_waddr = rd_pend_q ? rd_addr_q : ld_addr;
  assign mem_wdata = rd_pend_q ? {ent_mark, rem_next}
                               : {mark_q, (graph_q ? dur_q : '0)};

  // slot store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.scan) begin
      rd_data_q <= mem_q[scan_idx_q[IDX_W-1:0]];
    end
  end

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      wait_q  <= wait_time_ms_i;
      cont_q  <= continues_voice_i;
      prev_q  <= previous_voice_i;
      mark_q  <= used_later_i;
      graph_q <= sets_graph_i;
      dur_q   <= graph_duration_ms_i;
    end
    rd_addr_q <= scan_idx_q[IDX_W-1:0];
    if (free_hit) begin
      found_idx_q <= rd_addr_q;
    end
    if (cmd_i.load) begin
      out_index_q <= ld_slot_wide[vsa_pkg::VOICE_W-1:0];
      out_fail_q  <= ld_fail;
      out_used_q  <= used_wide[vsa_pkg::USED_W-1:0];
    end
  end

  // sweep and count control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_idx_q  <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.scan;
      if (cmd_i.start) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          scan_idx_q <= scan_idx_q + CNT_W'(1);
        end
        if (free_hit) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.load) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // status
  assign status_o.count_zero = count_q == '0;
  assign status_o.scan_last  = (scan_idx_q + CNT_W'(1)) == count_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign voice_index_o   = out_index_q;
  assign no_free_voice_o = out_fail_q;
  assign voices_used_o   = out_used_q;

endmodule

// ===== rtl/vsa_checker.sv =====
`include "voice_slot_allocator_core_defines.svh"

module vsa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        evt_valid_i,
  input logic                        evt_ready_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [vsa_pkg::VOICE_W-1:0] res_voice_index_i,
  input logic                        res_no_free_voice_i,
  input logic [vsa_pkg::USED_W-1:0]  res_voices_used_i
);

  // a stalled result stays offered
  `VSA_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i, "result dropped")

  // a stalled result keeps its fields
  `VSA_ASSERT_NEXT(a_res_stable, res_valid_i && !res_ready_i, $stable(res_voice_index_i) && $stable(res_no_free_voice_i) && $stable(res_voices_used_i), "result changed")

  // one event at a time: no accept right after an accept
  `VSA_ASSERT_NEXT(a_one_item, evt_valid_i && evt_ready_i, !evt_ready_i, "event taken while busy")

  // a new result is only loaded while the event side is closed
  `VSA_ASSERT(a_res_after_work, $rose(res_valid_i) |-> $past(!evt_ready_i), "result without work")

endmodule

bind voice_slot_allocator_core vsa_checker u_vsa_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .evt_valid_i         (evt_i.valid),
  .evt_ready_i         (evt_i.ready),
  .res_valid_i         (res_o.valid),
  .res_ready_i         (res_o.ready),
  .res_voice_index_i   (res_o.voice_index),
  .res_no_free_voice_i (res_o.no_free_voice),
  .res_voices_used_i   (res_o.voices_used)
);

// ===== test/voice_slot_allocator_core_tb.sv =====
module voice_slot_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_VOICES = 16;
  localparam int unsigned CLK_PERIOD = 20;
  // slowest sweep plus output register slack
  localparam int unsigned SETTLE_CYCLES = NUM_VOICES + 8;

  typedef struct packed {
    logic [vsa_pkg::WAIT_W-1:0]  wait_ms;
    logic                        cont;
    logic [vsa_pkg::VOICE_W-1:0] prev;
    logic                        later;
    logic                        graph;
    logic [vsa_pkg::DUR_W-1:0]   dur;
  } voice_evt_t;

  typedef struct packed {
    logic [vsa_pkg::VOICE_W-1:0] voice;
    logic                        full;
    logic [vsa_pkg::USED_W-1:0]  used;
  } voice_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  vsa_evt_if evt_if ();
  vsa_res_if res_if ();

  voice_slot_allocator_core #(
    .MAX_VOICES(NUM_VOICES)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt_if),
    .res_o (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // allocator state as predicted from accepted items
  logic [vsa_pkg::DUR_W-1:0] slot_remaining_ms [NUM_VOICES];
  logic                      slot_marked [NUM_VOICES];
  int unsigned               slot_total;

  voice_res_t  pending_allocs [$];
  bit          traffic_gaps;
  int unsigned sink_hold_cycles;
  int unsigned error_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned full_count;
  int unsigned continue_count;
  int unsigned expired_reuse_count;

  // countdown, then continue / reuse lowest expired unmarked / append
  function automatic voice_res_t allocate_voice(input voice_evt_t e);
    voice_res_t r;
    int unsigned i;
    int unsigned slot;
    bit found;
    bit no_slot;
    slot = 0;
    found = 1'b0;
    no_slot = 1'b0;
    for (i = 0; i < slot_total; i++) begin
      if (slot_remaining_ms[i] < e.wait_ms) begin
        slot_remaining_ms[i] = '0;
      end else begin
        slot_remaining_ms[i] = slot_remaining_ms[i] - e.wait_ms;
      end
    end
    if (e.cont) begin
      continue_count++;
      slot = 32'(e.prev);
      if (e.prev < NUM_VOICES) found = 1'b1;
      else no_slot = 1'b1;
    end else begin
      for (i = 0; i < slot_total && !found; i++) begin
        if (!slot_marked[i] && slot_remaining_ms[i] == '0) begin
          found = 1'b1;
          slot = i;
          expired_reuse_count++;
        end
      end
      if (!found && slot_total < NUM_VOICES) begin
        slot = slot_total;
        slot_total++;
        found = 1'b1;
      end else if (!found) begin
        slot = 0;
        no_slot = 1'b1;
      end
    end
    if (found) begin
      slot_marked[slot] = e.later;
      slot_remaining_ms[slot] = e.graph ? e.dur : '0;
    end
    if (no_slot) full_count++;
    r.voice = vsa_pkg::VOICE_W'(slot);
    r.full = no_slot;
    r.used = vsa_pkg::USED_W'(slot_total);
    return r;
  endfunction

  function automatic voice_evt_t make_event(input logic [vsa_pkg::WAIT_W-1:0] wait_ms,
                                            input logic cont,
                                            input logic [vsa_pkg::VOICE_W-1:0] prev,
                                            input logic later, input logic graph,
                                            input logic [vsa_pkg::DUR_W-1:0] dur);
    voice_evt_t e;
    e.wait_ms = wait_ms;
    e.cont = cont;
    e.prev = prev;
    e.later = later;
    e.graph = graph;
    e.dur = dur;
    return e;
  endfunction

  // busy: short waits keep slots alive so the store fills;
  // relaxed: long waits let slots expire
  function automatic voice_evt_t random_event(input bit busy);
    voice_evt_t e;
    int unsigned pick;
    int unsigned i;
    int unsigned marked [$];
    e.wait_ms = busy ? $urandom_range(0, 40) : $urandom_range(0, 3000);
    pick = $urandom_range(0, 19);
    if (pick == 0) e.wait_ms = $urandom();
    else if (pick == 1) e.wait_ms = '1;
    else if (pick == 2) e.wait_ms = '0;
    e.graph = ($urandom_range(0, 9) < 7);
    e.dur = $urandom_range(0, busy ? 2000 : 1500);
    pick = $urandom_range(0, 19);
    if (pick == 0) e.dur = $urandom();
    else if (pick == 1) e.dur = '1;
    e.later = ($urandom_range(0, 3) == 0);
    e.cont = ($urandom_range(0, 3) == 0);
    e.prev = vsa_pkg::VOICE_W'($urandom_range(0, NUM_VOICES - 1));
    // continuing a voice that was held for later use, else any allocated one, as a real score does
    if (e.cont && slot_total > 0 && $urandom_range(0, 3) != 0) begin
      for (i = 0; i < slot_total; i++) begin
        if (slot_marked[i]) marked.push_back(i);
      end
      if (marked.size() > 0) begin
        e.prev = vsa_pkg::VOICE_W'(marked[$urandom_range(0, marked.size() - 1)]);
      end else begin
        e.prev = vsa_pkg::VOICE_W'($urandom_range(0, slot_total - 1));
      end
    end
    return e;
  endfunction

  // drive one item and record its expected result on accept
  task automatic send_event(input voice_evt_t e);
    if (traffic_gaps && $urandom_range(0, 5) == 0) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    evt_if.valid             <= 1'b1;
    evt_if.wait_time_ms      <= e.wait_ms;
    evt_if.continues_voice   <= e.cont;
    evt_if.previous_voice    <= e.prev;
    evt_if.used_later        <= e.later;
    evt_if.sets_graph        <= e.graph;
    evt_if.graph_duration_ms <= e.dur;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
    pending_allocs.push_back(allocate_voice(e));
    sent_count++;
  endtask

  task automatic wait_for_drain();
    evt_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_allocs.size() != 0);
  endtask

  // growth from empty, expiry, store full, continued voices
  task automatic test_directed_cases();
    int k;
    traffic_gaps = 1'b0;
    send_event(make_event('0, 1'b0, 4'd0, 1'b0, 1'b1, '1));
    send_event(make_event('1, 1'b0, 4'd0, 1'b0, 1'b1, 32'd100));
    // voice not yet allocated is written anyway
    send_event(make_event('0, 1'b1, 4'd5, 1'b1, 1'b1, 32'd7));
    send_event(make_event('0, 1'b0, 4'd0, 1'b1, 1'b0, '0));
    for (k = 0; k < 14; k++) begin
      send_event(make_event('0, 1'b0, 4'd0, k[0], 1'b1, 32'd1000));
    end
    // every slot busy or marked
    send_event(make_event('0, 1'b0, 4'd0, 1'b0, 1'b1, '0));
    send_event(make_event('0, 1'b1, 4'd15, 1'b0, 1'b0, '0));
    send_event(make_event('0, 1'b0, 4'd9, 1'b0, 1'b1, 32'd50));
    // wait equal to the remaining time expires the slot exactly
    send_event(make_event(32'd100, 1'b0, 4'd0, 1'b0, 1'b0, '0));
    send_event(make_event(32'd1, 1'b1, 4'd1, 1'b0, 1'b1, '1));
    send_event(make_event(32'h8000_0000, 1'b0, 4'd10, 1'b1, 1'b1, 32'h5555_aaaa));
    wait_for_drain();
  endtask

  // mixed traffic with idling on both sides
  task automatic test_random_traffic();
    int k;
    traffic_gaps = 1'b1;
    for (k = 0; k < 800; k++) send_event(random_event((k / 40) % 2 == 0));
  endtask

  // receiver stalls long enough that the block backs up its input
  task automatic test_receiver_hold();
    int k;
    sink_hold_cycles = 300;
    for (k = 0; k < 30; k++) send_event(random_event(1'b1));
    wait_for_drain();
  endtask

  // sender stops until every result is back, then resumes
  task automatic test_sender_pause();
    int k;
    for (k = 0; k < 20; k++) send_event(random_event(1'b0));
    wait_for_drain();
    for (k = 0; k < 20; k++) send_event(random_event(1'b1));
    wait_for_drain();
  endtask

  // back-to-back items, no idling anywhere
  task automatic test_full_rate();
    int k;
    traffic_gaps = 1'b0;
    for (k = 0; k < 250; k++) send_event(random_event((k / 25) % 2 == 1));
    wait_for_drain();
  endtask

  // receiver ready: long hold, random stall bursts, else ready
  initial begin
    bit rdy;
    int unsigned stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (traffic_gaps && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      res_if.ready <= rdy;
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    voice_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      checked_count++;
      if (pending_allocs.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result voice_index=%0d no_free_voice=%0d voices_used=%0d",
                 $time, res_if.voice_index, res_if.no_free_voice, res_if.voices_used);
      end else begin
        want = pending_allocs.pop_front();
        if (res_if.voice_index !== want.voice) begin
          error_count++;
          $display("%0t: voice_index expected %0d actual %0d",
                   $time, want.voice, res_if.voice_index);
        end
        if (res_if.no_free_voice !== want.full) begin
          error_count++;
          $display("%0t: no_free_voice expected %0d actual %0d",
                   $time, want.full, res_if.no_free_voice);
        end
        if (res_if.voices_used !== want.used) begin
          error_count++;
          $display("%0t: voices_used expected %0d actual %0d",
                   $time, want.used, res_if.voices_used);
        end
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < NUM_VOICES; i++) begin
      slot_remaining_ms[i] = '0;
      slot_marked[i] = 1'b0;
    end
    slot_total = 0;
    traffic_gaps = 1'b0;
    sink_hold_cycles = 0;
    error_count = 0;
    sent_count = 0;
    checked_count = 0;
    full_count = 0;
    continue_count = 0;
    expired_reuse_count = 0;
    rst_ni                   <= 1'b0;
    evt_if.valid             <= 1'b0;
    evt_if.wait_time_ms      <= '0;
    evt_if.continues_voice   <= 1'b0;
    evt_if.previous_voice    <= '0;
    evt_if.used_later        <= 1'b0;
    evt_if.sets_graph        <= 1'b0;
    evt_if.graph_duration_ms <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_traffic();
    test_receiver_hold();
    test_sender_pause();
    test_full_rate();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("run covered %0d events and %0d checked results: %0d store-full, %0d continued,",
             sent_count, checked_count, full_count, continue_count);
    $display("%0d expired-slot reuses, with long receiver hold and a drained sender pause",
             expired_reuse_count);
    if (error_count == 0) begin
      $display("voice_slot_allocator_core test passed");
    end else begin
      $display("voice_slot_allocator_core test failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20_000_000;
    $display("voice_slot_allocator_core test failed");
    $finish;
  end

endmodule
